>>> hw/rtl/shcp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shcp_pkg
// Shared types and constants of the SH coefficient half-precision packer.
// ----------------------------------------------------------------------------
package shcp_pkg;

  localparam int unsigned CpsW            = 6;
  localparam int unsigned CoeffW          = 32;
  localparam int unsigned HalfW           = 16;
  localparam int unsigned WordW           = 32;
  localparam int unsigned StoreWords      = 24;   // 48 halves, two per word
  localparam int unsigned WordAw          = 5;
  localparam int unsigned IdxW            = 5;    // index within a channel, at most 20
  localparam int unsigned SlotW           = 6;
  localparam int unsigned CpsReset        = 45;
  localparam int unsigned MaxPerChannelDefault  = 15;
  localparam int unsigned WordsPerRecordDefault = 24;

  localparam logic [HalfW-2:0] HalfSat = 15'h7BFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;     // input transfer this cycle
    logic              rd_en;    // fetch one word into the output register
    logic [WordAw-1:0] rd_addr;
    logic              clear;    // drop the record store and counters
  } shcp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rec_end;               // the item on the input completes a record
  } shcp_sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/sh_coeff_half_interleave_packer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sh_coeff_half_interleave_packer_core
// Converts float32 SH coefficients to float16 and packs them, channel
// interleaved, into 32-bit words at the end of each record.
// ----------------------------------------------------------------------------
//   Port group   Dir  Payload
//   s_axis_*     in   tdata[31:0] = coeff_bits
//   m_axis_*     out  tdata[31:0] = packed_word, tlast = last_word
//   cfg_*_i      in   cfg_wdata_i[5:0] = coeffs_per_splat
//
// An input transfer is taken when the input is ready; items of a record follow
// back to back. After the item that ends a record the input is held off while
// the store is read out, one word per cycle when the sink is ready, paced by
// the single store read port. The next record may start while the final word
// still waits in the output register. After reset coeffs_per_splat is 45 and
// the store is empty.
// ----------------------------------------------------------------------------
module sh_coeff_half_interleave_packer_core #(
  parameter int unsigned MAX_PER_CHANNEL  = shcp_pkg::MaxPerChannelDefault,
  parameter int unsigned WORDS_PER_RECORD = shcp_pkg::WordsPerRecordDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output      logic                        s_axis_tready,
  input  wire logic [31:0]                 s_axis_tdata,   // [31:0] coeff_bits
  output      logic                        m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output      logic [31:0]                 m_axis_tdata,   // [31:0] packed_word
  output      logic                        m_axis_tlast,
  input  wire logic                        cfg_we_i,
  input  wire logic [shcp_pkg::CpsW-1:0]   cfg_wdata_i
);

  shcp_pkg::shcp_cmd_t cmd;
  shcp_pkg::shcp_sts_t sts;

  shcp_ctrl #(
    .WORDS_PER_RECORD(WORDS_PER_RECORD)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_last_o (m_axis_tlast),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  shcp_datapath #(
    .MAX_PER_CHANNEL(MAX_PER_CHANNEL)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .coeff_i    (s_axis_tdata),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .word_o     (m_axis_tdata)
  );

  // No store read while items are being collected.
  a_no_read_in_collect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !cmd.rd_en)
    else $error("store read while input is open");

  // A record-ending transfer closes the input for the readout.
  a_close_after_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load && sts.rec_end) |=> !s_axis_tready)
    else $error("input stayed open after record end");

  // Fetching the last word reopens the input and tags the word as last.
  a_reopen_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear |=> (s_axis_tready && m_axis_tvalid && m_axis_tlast))
    else $error("readout end not handled");

endmodule
`default_nettype wire

>>> hw/rtl/shcp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shcp_ctrl
// Controller: collects items until a record ends, then reads out the store
// one word per cycle into the output register while the sink keeps up.
// ----------------------------------------------------------------------------
module shcp_ctrl #(
  parameter int unsigned WORDS_PER_RECORD = shcp_pkg::WordsPerRecordDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic               out_last_o,
  input  wire shcp_pkg::shcp_sts_t sts_i,
  output      shcp_pkg::shcp_cmd_t cmd_o
);

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } state_e;

  localparam logic [shcp_pkg::WordAw-1:0] LastWord =
    shcp_pkg::WordAw'(WORDS_PER_RECORD - 1);

  state_e                      state_q;
  logic                        in_ready_q;
  logic                        out_valid_q;
  logic                        out_last_q;
  logic [shcp_pkg::WordAw-1:0] word_q;

  logic load;
  logic issue;
  logic issue_last;

  assign load       = in_valid_i && in_ready_q;
  // The output register doubles as the read data register of the store.
  assign issue      = (state_q == ST_DRAIN) && (!out_valid_q || out_ready_i);
  assign issue_last = issue && (word_q == LastWord);

  always_comb begin
    cmd_o.load    = load;
    cmd_o.rd_en   = issue;
    cmd_o.rd_addr = word_q;
    cmd_o.clear   = issue_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COLLECT;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      word_q      <= '0;
    end else begin
      if (issue) begin
        out_valid_q <= 1'b1;
        out_last_q  <= issue_last;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_COLLECT: begin
          if (load && sts_i.rec_end) begin
            state_q    <= ST_DRAIN;
            in_ready_q <= 1'b0;
            word_q     <= '0;
          end
        end
        ST_DRAIN: begin
          if (issue) begin
            word_q <= word_q + 1'b1;
            if (issue_last) begin
              state_q    <= ST_COLLECT;
              in_ready_q <= 1'b1;
            end
          end
        end
        default: begin
          state_q <= ST_COLLECT;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;
  assign out_last_o  = out_last_q;

endmodule
`default_nettype wire

>>> hw/rtl/shcp_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shcp_datapath
// Float32 to float16 truncating conversion, record counters, interleaved
// half store with per-slot valid bits, and the registered read port.
// ----------------------------------------------------------------------------
module shcp_datapath #(
  parameter int unsigned MAX_PER_CHANNEL = shcp_pkg::MaxPerChannelDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [shcp_pkg::CpsW-1:0]   cfg_wdata_i,
  input  wire logic [shcp_pkg::CoeffW-1:0] coeff_i,
  input  wire shcp_pkg::shcp_cmd_t         cmd_i,
  output      shcp_pkg::shcp_sts_t         sts_o,
  output      logic [shcp_pkg::WordW-1:0]  word_o
);

  localparam int unsigned Words = shcp_pkg::StoreWords;
  localparam int unsigned IdxW  = shcp_pkg::IdxW;
  localparam logic [shcp_pkg::CpsW-1:0] CpsInit = shcp_pkg::CpsW'(shcp_pkg::CpsReset);
  localparam logic [IdxW-1:0] CpcInit = IdxW'(shcp_pkg::CpsReset / 3);
  localparam logic [IdxW:0]   MaxIdx  = (IdxW + 1)'(MAX_PER_CHANNEL);

  // Truncating conversion; the exponent windows are tested on the biased field.
  function automatic logic [shcp_pkg::HalfW-1:0] to_half(
    input logic [shcp_pkg::CoeffW-1:0] bits
  );
    logic        sgn;
    logic [7:0]  ex;
    logic [22:0] man;
    logic [23:0] full;
    logic [4:0]  sh;
    logic [23:0] sub;
    logic [4:0]  hex;
    logic [14:0] mag;
    sgn  = bits[31];
    ex   = bits[30:23];
    man  = bits[22:0];
    full = {1'b1, man};
    sh   = 5'(8'd126 - ex);
    sub  = full >> sh;
    hex  = 5'(ex - 8'd112);
    if (ex > 8'd142) begin
      mag = shcp_pkg::HalfSat;
    end else if (ex < 8'd103) begin
      mag = '0;
    end else if (ex < 8'd113) begin
      mag = sub[14:0];
    end else begin
      mag = {hex, man[22:13]};
    end
    return {sgn, mag};
  endfunction

  logic [shcp_pkg::CpsW-1:0] cps_q;
  logic [IdxW-1:0]           cpc_q;
  logic [IdxW-1:0]           idx_q;
  logic [1:0]                ch_q;
  logic [shcp_pkg::CpsW-1:0] item_q;

  logic [shcp_pkg::HalfW-1:0] mem_even [Words];
  logic [shcp_pkg::HalfW-1:0] mem_odd  [Words];
  logic [Words-1:0]           vld_even_q;
  logic [Words-1:0]           vld_odd_q;
  logic [shcp_pkg::HalfW-1:0] rd_even_q;
  logic [shcp_pkg::HalfW-1:0] rd_odd_q;
  logic                       rd_even_vld_q;
  logic                       rd_odd_vld_q;

  logic [13:0]               cpc_prod;
  logic                      active;
  logic [1:0]                ch_eff;
  logic                      in_chan;
  logic                      wr_en;
  logic [shcp_pkg::SlotW-1:0] slot;
  logic [shcp_pkg::WordAw-1:0] slot_word;
  logic [shcp_pkg::HalfW-1:0] half;
  logic [IdxW:0]             idx_inc;

  // Division by three as a multiply by 171 over 512, exact for every 6-bit input.
  assign cpc_prod  = 14'(cfg_wdata_i) * 14'd171;
  assign active    = cmd_i.load && (cps_q != '0);
  assign ch_eff    = (cpc_q == '0) ? 2'd3 : ch_q;
  assign in_chan   = (ch_eff != 2'd3);
  assign wr_en     = active && in_chan && ({1'b0, idx_q} < MaxIdx);
  assign slot      = shcp_pkg::SlotW'(idx_q) * shcp_pkg::SlotW'(3) + shcp_pkg::SlotW'(ch_eff);
  assign slot_word = slot[shcp_pkg::SlotW-1:1];
  assign half      = to_half(coeff_i);
  assign idx_inc   = {1'b0, idx_q} + 1'b1;

  always_comb begin
    sts_o.rec_end = (cps_q == '0) ||
                    ({1'b0, item_q} + 1'b1 == {1'b0, cps_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cps_q      <= CpsInit;
      cpc_q      <= CpcInit;
      idx_q      <= '0;
      ch_q       <= '0;
      item_q     <= '0;
      vld_even_q <= '0;
      vld_odd_q  <= '0;
    end else if (cfg_we_i) begin
      cps_q      <= cfg_wdata_i;
      cpc_q      <= cpc_prod[13:9];
      idx_q      <= '0;
      ch_q       <= '0;
      item_q     <= '0;
      vld_even_q <= '0;
      vld_odd_q  <= '0;
    end else if (cmd_i.clear) begin
      idx_q      <= '0;
      ch_q       <= '0;
      item_q     <= '0;
      vld_even_q <= '0;
      vld_odd_q  <= '0;
    end else if (active) begin
      item_q <= item_q + 1'b1;
      if (in_chan) begin
        if (idx_inc >= {1'b0, cpc_q}) begin
          idx_q <= '0;
          ch_q  <= ch_eff + 1'b1;
        end else begin
          idx_q <= idx_inc[IdxW-1:0];
          ch_q  <= ch_eff;
        end
      end else begin
        ch_q <= ch_eff;
      end
      if (wr_en) begin
        if (slot[0]) begin
          vld_odd_q[slot_word] <= 1'b1;
        end else begin
          vld_even_q[slot_word] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && !slot[0]) begin
      mem_even[slot_word] <= half;
    end
    if (wr_en && slot[0]) begin
      mem_odd[slot_word] <= half;
    end
    if (cmd_i.rd_en) begin
      rd_even_q <= mem_even[cmd_i.rd_addr];
      rd_odd_q  <= mem_odd[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_even_vld_q <= 1'b0;
      rd_odd_vld_q  <= 1'b0;
    end else if (cmd_i.rd_en) begin
      rd_even_vld_q <= vld_even_q[cmd_i.rd_addr];
      rd_odd_vld_q  <= vld_odd_q[cmd_i.rd_addr];
    end
  end

  // A slot not written since the last clear, configuration write or reset reads as zero.
  assign word_o = {rd_odd_vld_q  ? rd_odd_q  : '0,
                   rd_even_vld_q ? rd_even_q : '0};

endmodule
`default_nettype wire
